>>> sv/spq_pkg.sv
// spq_pkg: request and result types, operation and status codes for the
// sorted priority queue. No dependencies; used by every module of the block.
`default_nettype none

package spq_pkg;

  localparam int KEY_W     = 32;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_PUSH_FULL = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic signed [KEY_W-1:0] key_in;
  } cmd_req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] top_key;
    logic                    is_empty;
    logic [CNT_OUT_W-1:0]    entry_count;
    logic [STAT_W-1:0]       status;
  } res_req_t;

  // controller to datapath
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> sv/spq_ctrl.sv
// spq_ctrl: handshake controller for the sorted priority queue; decodes the
// operation, issues datapath commands and holds the result status.
// Depends on spq_pkg.
`default_nettype none

module spq_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cmd_valid,
  output logic                          cmd_stall,
  input  wire logic [spq_pkg::OP_W-1:0] opcode,
  input  spq_pkg::dp_stat_t             dp_stat,
  output spq_pkg::dp_cmd_t              dp_cmd,
  output logic                          res_valid,
  input  wire logic                     res_stall,
  output logic [spq_pkg::STAT_W-1:0]    res_status
);
  import spq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic              state;
  logic              state_next;
  logic              accept;
  logic [STAT_W-1:0] status;
  logic [STAT_W-1:0] status_next;
  dp_cmd_t           op_cmd;

  // a pending result that is not taken blocks the next request
  assign cmd_stall = (state == S_HOLD) && res_stall;
  assign accept    = cmd_valid && !cmd_stall;

  // operation decode against the current fill state
  always_comb begin
    op_cmd      = '0;
    status_next = ST_OK;
    unique case (opcode)
      OP_PUSH: begin
        if (dp_stat.full) begin
          status_next = ST_PUSH_FULL;
        end else begin
          op_cmd.push = 1'b1;
        end
      end
      OP_POP: begin
        if (dp_stat.empty) begin
          status_next = ST_POP_EMPTY;
        end else begin
          op_cmd.pop = 1'b1;
        end
      end
      OP_CLEAR: begin
        op_cmd.clear = 1'b1;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  assign dp_cmd = accept ? op_cmd : '0;

  // result pending state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!accept && !res_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // status travels with the result
  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

  assign res_valid  = (state == S_HOLD);
  assign res_status = status;

endmodule

`default_nettype wire

>>> sv/spq_dp.sv
// spq_dp: compare-and-shift cell array holding the keys in descending order,
// plus the entry counter. Depends on spq_pkg.
`default_nettype none

module spq_dp #(
  parameter int CAPACITY = 16,
  parameter int CNT_W    = 5
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  spq_pkg::dp_cmd_t                     dp_cmd,
  input  wire logic signed [spq_pkg::KEY_W-1:0] key,
  output spq_pkg::dp_stat_t                    dp_stat,
  output logic [CNT_W-1:0]                     count,
  output logic signed [spq_pkg::KEY_W-1:0]     top_key,
  output logic [spq_pkg::CNT_OUT_W-1:0]        entry_count
);
  import spq_pkg::*;

  logic signed [KEY_W-1:0]        keys [CAPACITY];
  logic [CAPACITY-1:0]            ge;
  logic [CNT_W+CNT_OUT_W-1:0]     count_wide;

  // one cell per slot: keep, take the new key, shift toward the tail on push or toward the head on pop
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

    // slot holds a key that stays ahead of the new one
    assign ge[i] = (IDX < count) && (keys[i] >= key);

    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (dp_cmd.push && !ge[i]) begin
          keys[i] <= key;
        end else if (dp_cmd.pop) begin
          if (CAPACITY > 1) begin
            keys[i] <= keys[(i + 1) % CAPACITY];
          end
        end
      end
    end else if (i == CAPACITY - 1) begin : g_tail
      always_ff @(posedge clk) begin
        if (dp_cmd.push && !ge[i]) begin
          keys[i] <= ge[i-1] ? key : keys[i-1];
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (dp_cmd.push && !ge[i]) begin
          keys[i] <= ge[i-1] ? key : keys[i-1];
        end else if (dp_cmd.pop) begin
          keys[i] <= keys[i+1];
        end
      end
    end
  end

  // entry counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (dp_cmd.clear) begin
      count <= '0;
    end else if (dp_cmd.push) begin
      count <= count + CNT_W'(1);
    end else if (dp_cmd.pop) begin
      count <= count - CNT_W'(1);
    end
  end

  assign dp_stat.full  = (count == CNT_W'(CAPACITY));
  assign dp_stat.empty = (count == '0);

  // result view of the store
  assign count_wide  = {{CNT_OUT_W{1'b0}}, count};
  assign entry_count = count_wide[CNT_OUT_W-1:0];
  assign top_key     = dp_stat.empty ? '0 : keys[0];

endmodule

`default_nettype wire

>>> sv/sorted_priority_queue.sv
// sorted_priority_queue: max-first priority queue of signed keys in a sorted
// cell array. Its result appears in the cycle after acceptance.
// Throughput: one push, pop or clear per cycle while no pending result is
// stalled; all slots insert or shift at once. Reset empties the queue and
// drops any pending result. Depends on spq_pkg, spq_ctrl and spq_dp.
`default_nettype none

module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_stall,
  input  spq_pkg::cmd_req_t      cmd,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output spq_pkg::res_req_t      res
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  dp_cmd_t                 dp_cmd;
  dp_stat_t                dp_stat;
  logic [CNT_W-1:0]        count;
  logic signed [KEY_W-1:0] top_key;
  logic [CNT_OUT_W-1:0]    entry_count;
  logic [STAT_W-1:0]       res_status;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .opcode     (cmd.opcode),
    .dp_stat    (dp_stat),
    .dp_cmd     (dp_cmd),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_status (res_status)
  );

  spq_dp #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .dp_cmd      (dp_cmd),
    .key         (cmd.key_in),
    .dp_stat     (dp_stat),
    .count       (count),
    .top_key     (top_key),
    .entry_count (entry_count)
  );

  // result assembly
  assign res.top_key     = top_key;
  assign res.is_empty    = dp_stat.empty;
  assign res.entry_count = entry_count;
  assign res.status      = res_status;

`ifndef SYNTHESIS
  // never more entries than slots
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // a stall only happens while a result is pending
  a_stall_pending: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> res_valid)
    else $error("request stalled with no pending result");

  // a successful pop removes exactly one entry
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall && cmd.opcode == OP_POP && !dp_stat.empty)
      |=> count == $past(count) - CNT_W'(1))
    else $error("pop did not remove one entry");

  // a full-queue push report matches the counter
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_PUSH_FULL) |-> count == CNT_W'(CAPACITY))
    else $error("push-full status with free slots");
`endif

endmodule

`default_nettype wire

>>> bench/testbench.sv
// testbench: self-checking bench for sorted_priority_queue, directed and random
// push, pop and clear requests checked against an in-bench queue predictor.
// Depends on spq_pkg and the sorted_priority_queue RTL.
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH    = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  // opcode the block must ignore
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fffffff;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh80000000;

  // traffic mix of a random stretch
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_stall;
  cmd_req_t cmd       = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  res_req_t res;

  // predictor state
  logic signed [KEY_W-1:0] model_keys [QUEUE_DEPTH];
  int                      model_count = 0;
  res_req_t                expected_results [$];

  // run control and tallies
  bit idle_on     = 1'b1;
  int stall_left  = 0;
  int quiet_cycles = 0;
  int mismatch_count = 0;
  int n_push = 0, n_pop = 0, n_clear = 0, n_unused = 0;
  int n_full_push = 0, n_empty_pop = 0, n_results = 0;

  res_req_t want;
  logic     cmd_acc, res_acc;

  sorted_priority_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // apply one request to the predicted queue and return the expected result
  function automatic res_req_t apply_queue_op(input cmd_req_t r);
    res_req_t o;
    int       pos;
    o.status = ST_OK;
    case (r.opcode)
      OP_PUSH: begin
        if (model_count >= QUEUE_DEPTH) begin
          o.status = ST_PUSH_FULL;
        end else begin
          // new key goes behind every key greater or equal
          pos = 0;
          while (pos < model_count && $signed(model_keys[pos]) >= $signed(r.key_in))
            pos++;
          for (int i = model_count; i > pos; i--)
            model_keys[i] = model_keys[i-1];
          model_keys[pos] = r.key_in;
          model_count++;
        end
      end
      OP_POP: begin
        if (model_count == 0) begin
          o.status = ST_POP_EMPTY;
        end else begin
          for (int i = 1; i < model_count; i++)
            model_keys[i-1] = model_keys[i];
          model_count--;
        end
      end
      OP_CLEAR: begin
        model_count = 0;
      end
      default: begin
      end
    endcase
    o.top_key     = (model_count > 0) ? model_keys[0] : '0;
    o.is_empty    = (model_count == 0);
    o.entry_count = model_count[CNT_OUT_W-1:0];
    return o;
  endfunction

  function automatic cmd_req_t make_req(input logic [OP_W-1:0] op,
                                        input logic signed [KEY_W-1:0] key);
    cmd_req_t r;
    r.opcode = op;
    r.key_in = key;
    return r;
  endfunction

  // keys lean toward a narrow band so duplicates and ties are common
  function automatic logic signed [KEY_W-1:0] random_key();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4)
      return $signed($urandom_range(0, 14)) - 7;
    if (pick == 4) begin
      case ($urandom_range(0, 3))
        0: return KEY_MAX;
        1: return KEY_MIN;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  // present one request and hold it until accepted
  task automatic send_request(input cmd_req_t r);
    if (idle_on && $urandom_range(0, 99) < 15) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= r;
    do @(posedge clk); while (cmd_stall);
  endtask

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      stall_left <= 0;
      res_stall  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_stall  <= 1'b1;
    end else if ($urandom_range(0, 99) < 12) begin
      stall_left <= $urandom_range(0, 8);
      res_stall  <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // predict on each accepted request, check each accepted result, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      cmd_acc = cmd_valid && !cmd_stall;
      res_acc = res_valid && !res_stall;
      if (cmd_acc) begin
        want = apply_queue_op(cmd);
        expected_results.push_back(want);
        case (cmd.opcode)
          OP_PUSH:  n_push++;
          OP_POP:   n_pop++;
          OP_CLEAR: n_clear++;
          default:  n_unused++;
        endcase
        if (want.status == ST_PUSH_FULL) n_full_push++;
        if (want.status == ST_POP_EMPTY) n_empty_pop++;
      end
      if (res_acc) begin
        n_results++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: top %0d empty %0b count %0d status %0d",
                     res.top_key, res.is_empty, res.entry_count, res.status);
        end else begin
          want = expected_results.pop_front();
          if (res.top_key !== want.top_key || res.is_empty !== want.is_empty ||
              res.entry_count !== want.entry_count || res.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("mismatch on result %0d: expected top %0d empty %0b count %0d status %0d, got top %0d empty %0b count %0d status %0d",
                       n_results, want.top_key, want.is_empty, want.entry_count,
                       want.status, res.top_key, res.is_empty, res.entry_count,
                       res.status);
          end
        end
      end
      if (cmd_acc || res_acc) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles", quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // pop, clear and unused opcode on an empty queue
  task automatic test_empty_queue();
    idle_on = 1'b1;
    send_request(make_req(OP_POP, KEY_MAX));
    send_request(make_req(OP_CLEAR, KEY_MIN));
    send_request(make_req(OP_UNUSED, '1));
  endtask

  // fill with extremes and ties, overflow, send an unused opcode, then pop and clear
  task automatic test_fill_and_overflow();
    logic signed [KEY_W-1:0] fill_keys [QUEUE_DEPTH] = '{
      32'sd0, -32'sd1, 32'sd1, KEY_MIN, 32'sd5, 32'sd5, -32'sd5, 32'sh40000000,
      -32'sd100, 32'sd100, KEY_MAX, 32'sd5, KEY_MIN, -32'sh40000000, KEY_MAX, 32'sd0};
    idle_on = 1'b1;
    foreach (fill_keys[i])
      send_request(make_req(OP_PUSH, fill_keys[i]));
    send_request(make_req(OP_PUSH, KEY_MAX));
    send_request(make_req(OP_UNUSED, KEY_MIN));
    send_request(make_req(OP_POP, '0));
    send_request(make_req(OP_POP, '0));
    send_request(make_req(OP_CLEAR, '0));
  endtask

  // stretches of fill, drain or mixed traffic with random keys
  task automatic run_random_requests(input int n);
    int       mode;
    int       roll;
    cmd_req_t r;
    mode = MODE_MIXED;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) mode = $urandom_range(MODE_FILL, MODE_MIXED);
      roll     = $urandom_range(0, 99);
      r.key_in = random_key();
      if (roll < 3)                r.opcode = OP_CLEAR;
      else if (roll < 5)           r.opcode = OP_UNUSED;
      else if (mode == MODE_FILL)  r.opcode = (roll < 75) ? OP_PUSH : OP_POP;
      else if (mode == MODE_DRAIN) r.opcode = (roll < 30) ? OP_PUSH : OP_POP;
      else                         r.opcode = (roll < 52) ? OP_PUSH : OP_POP;
      send_request(r);
    end
  endtask

  task automatic test_random_with_idling();
    idle_on = 1'b1;
    run_random_requests(700);
  endtask

  task automatic test_random_back_to_back();
    idle_on = 1'b0;
    run_random_requests(227);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_fill_and_overflow();
    test_random_with_idling();
    test_random_back_to_back();
    cmd_valid <= 1'b0;

    // drain outstanding results, then wait before the final check
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      mismatch_count++;
    end

    $display("covered %0d pushes, %0d pops, %0d clears, %0d unused opcodes",
             n_push, n_pop, n_clear, n_unused);
    $display("%0d pushes hit a full queue, %0d pops hit an empty one, %0d results checked",
             n_full_push, n_empty_pop, n_results);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sorted_priority_queue.f
sv/spq_pkg.sv
sv/spq_ctrl.sv
sv/spq_dp.sv
sv/sorted_priority_queue.sv
bench/testbench.sv
